FILE: design/mae_pkg.sv
// Shared types for the matrix arithmetic engine: operation codes and the
// controller-to-datapath command and status words. No dependencies.
`default_nettype none
package mae_pkg;

	typedef enum logic [2:0] {
		FN_LOAD_A = 3'd0,
		FN_LOAD_B = 3'd1,
		FN_ADD    = 3'd2,
		FN_SUB    = 3'd3,
		FN_MUL    = 3'd4,
		FN_SCALE  = 3'd5,
		FN_TRANS  = 3'd6,
		FN_NONE   = 3'd7
	} func_t;

	localparam int unsigned CFG_W = 4;

	typedef enum logic [1:0] {
		REG_ROWS_A = 2'd0,
		REG_COLS_A = 2'd1,
		REG_ROWS_B = 2'd2,
		REG_COLS_B = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic  vld;     // read issued this cycle
		func_t op;
		logic  first;   // first term of an element: clear accumulator
		logic  last_k;  // final term of an element: emit
		logic  last;    // final element of the matrix
		logic  err;
		logic  scl_ld;  // capture scale factor
		logic  wr_a;
		logic  wr_b;
	} cmd_t;

	typedef struct packed {
		logic done;     // final element leaves the output register
	} sts_t;

endpackage
`default_nettype wire

FILE: design/mae_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mae_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

FILE: design/mae_ctrl.sv
// Controller: dimension registers, load decode and the element/term sequencer.
// Depends on mae_pkg.
`default_nettype none
module mae_ctrl #(
	parameter int unsigned MAX_DIM = 8,
	parameter int unsigned IDX_W   = 3
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [2:0]              func,
	input  wire logic [IDX_W-1:0]        row,
	input  wire logic [IDX_W-1:0]        col,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [mae_pkg::CFG_W-1:0] cfg_data,
	output mae_pkg::cmd_t                cmd,
	output logic [IDX_W-1:0]             ra_row,
	output logic [IDX_W-1:0]             ra_col,
	output logic [IDX_W-1:0]             rb_row,
	output logic [IDX_W-1:0]             rb_col,
	output logic [IDX_W-1:0]             o_row,
	output logic [IDX_W-1:0]             o_col,
	input  wire mae_pkg::sts_t           sts
);
	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

	state_t state_q;
	logic [mae_pkg::CFG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [IDX_W-1:0] ra_m1, ca_m1, rb_m1, cb_m1;
	logic [IDX_W-1:0] nr_m1_q, nc_m1_q, nk_m1_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	mae_pkg::func_t op_q, fn;
	logic err_q, acc_in, last_k, last_el;

	// effective dimension minus one: zero acts as one, large values clip
	function automatic logic [IDX_W-1:0] last_idx(input logic [mae_pkg::CFG_W-1:0] d);
		logic [5:0] e;
		e = {2'b00, d};
		if (e == 6'd0) begin
			e = 6'd1;
		end
		if (e > 6'(MAX_DIM)) begin
			e = 6'(MAX_DIM);
		end
		e = e - 6'd1;
		return e[IDX_W-1:0];
	endfunction

	assign ra_m1 = last_idx(rows_a_q);
	assign ca_m1 = last_idx(cols_a_q);
	assign rb_m1 = last_idx(rows_b_q);
	assign cb_m1 = last_idx(cols_b_q);

	assign fn        = mae_pkg::func_t'(func);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign acc_in    = start && !busy;

	assign last_k  = (op_q != mae_pkg::FN_MUL) || err_q || (k_q == nk_m1_q);
	assign last_el = last_k && (i_q == nr_m1_q) && (j_q == nc_m1_q);

	always_comb begin
		cmd        = '0;
		cmd.op     = op_q;
		cmd.vld    = (state_q == ST_RUN);
		cmd.first  = (k_q == '0);
		cmd.last_k = last_k;
		cmd.last   = last_el;
		cmd.err    = err_q;
		cmd.scl_ld = acc_in && (fn == mae_pkg::FN_SCALE);
		cmd.wr_a   = acc_in && (fn == mae_pkg::FN_LOAD_A) && (row <= ra_m1) && (col <= ca_m1);
		cmd.wr_b   = acc_in && (fn == mae_pkg::FN_LOAD_B) && (row <= rb_m1) && (col <= cb_m1);
		ra_row = i_q;
		ra_col = j_q;
		rb_row = i_q;
		rb_col = j_q;
		unique case (op_q)
			mae_pkg::FN_MUL: begin
				ra_col = k_q;
				rb_row = k_q;
			end
			mae_pkg::FN_TRANS: begin
				ra_row = j_q;
				ra_col = i_q;
			end
			default: begin
			end
		endcase
	end

	assign o_row = i_q;
	assign o_col = j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rows_a_q <= mae_pkg::CFG_W'(1);
			cols_a_q <= mae_pkg::CFG_W'(1);
			rows_b_q <= mae_pkg::CFG_W'(1);
			cols_b_q <= mae_pkg::CFG_W'(1);
			op_q     <= mae_pkg::FN_NONE;
			err_q    <= 1'b0;
			nr_m1_q  <= '0;
			nc_m1_q  <= '0;
			nk_m1_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (mae_pkg::reg_idx_t'(cfg_index))
					mae_pkg::REG_ROWS_A: rows_a_q <= cfg_data;
					mae_pkg::REG_COLS_A: cols_a_q <= cfg_data;
					mae_pkg::REG_ROWS_B: rows_b_q <= cfg_data;
					mae_pkg::REG_COLS_B: cols_b_q <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_in && fn != mae_pkg::FN_LOAD_A && fn != mae_pkg::FN_LOAD_B
							&& fn != mae_pkg::FN_NONE) begin
						state_q <= ST_RUN;
						op_q    <= fn;
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						nr_m1_q <= ra_m1;
						nc_m1_q <= ca_m1;
						nk_m1_q <= ca_m1;
						err_q   <= 1'b0;
						case (fn)
							mae_pkg::FN_ADD, mae_pkg::FN_SUB:
								err_q <= (ra_m1 != rb_m1) || (ca_m1 != cb_m1);
							mae_pkg::FN_MUL: begin
								nc_m1_q <= cb_m1;
								err_q   <= (ca_m1 != rb_m1);
							end
							mae_pkg::FN_TRANS: begin
								nr_m1_q <= ca_m1;
								nc_m1_q <= ra_m1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					if (!last_k) begin
						k_q <= k_q + 1'b1;
					end else begin
						k_q <= '0;
						if (last_el) begin
							state_q <= ST_DRAIN;
						end else if (j_q == nc_m1_q) begin
							j_q <= '0;
							i_q <= i_q + 1'b1;
						end else begin
							j_q <= j_q + 1'b1;
						end
					end
				end
				ST_DRAIN: begin
					if (sts.done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_a || cmd.wr_b) |-> !busy) else $error("load write while busy");
	a_done_drain: assert property (@(posedge clk) disable iff (!arst_n)
		sts.done |-> (state_q == ST_DRAIN)) else $error("final word outside drain");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q <= nk_m1_q)) else $error("term index overrun");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_a && cmd.wr_b)) else $error("both stores written");
`endif
endmodule
`default_nettype wire

FILE: design/mae_dp.sv
// Datapath: A and B stores, multiply/add term stage, accumulator,
// shift and saturation, result register. Depends on mae_pkg and mae_ram.
`default_nettype none
module mae_dp #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned IDX_W      = 3,
	parameter int unsigned ACC_W      = 68
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mae_pkg::cmd_t         cmd,
	input  wire logic [IDX_W-1:0]      wr_row,
	input  wire logic [IDX_W-1:0]      wr_col,
	input  wire logic [DATA_WIDTH-1:0] wr_data,
	input  wire logic [DATA_WIDTH-1:0] scalar_in,
	input  wire logic [IDX_W-1:0]      ra_row,
	input  wire logic [IDX_W-1:0]      ra_col,
	input  wire logic [IDX_W-1:0]      rb_row,
	input  wire logic [IDX_W-1:0]      rb_col,
	input  wire logic [IDX_W-1:0]      o_row,
	input  wire logic [IDX_W-1:0]      o_col,
	output mae_pkg::sts_t              sts,
	output logic                       out_valid,
	output logic [DATA_WIDTH-1:0]      result,
	output logic [IDX_W-1:0]           out_row,
	output logic [IDX_W-1:0]           out_col,
	output logic                       last,
	output logic                       dim_error,
	output logic                       saturated
);
	localparam int unsigned DW    = DATA_WIDTH;
	localparam int unsigned DEPTH = 1 << (2 * IDX_W);

	logic [DW-1:0] rd_a, rd_b, scl_q;
	mae_pkg::cmd_t cmd_s1, cmd_s2;
	logic [IDX_W-1:0] row_s1, col_s1, row_s2, col_s2;
	logic signed [DW-1:0]    ma, mb;
	logic signed [2*DW-1:0]  prod;
	logic signed [ACC_W-1:0] term_c, term_s2, acc_q, acc_next, shifted, fin;
	logic fits, out_valid_q, last_q;

	mae_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
		.clk(clk), .we(cmd.wr_a), .waddr({wr_row, wr_col}), .wdata(wr_data),
		.raddr({ra_row, ra_col}), .rdata(rd_a)
	);
	mae_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
		.clk(clk), .we(cmd.wr_b), .waddr({wr_row, wr_col}), .wdata(wr_data),
		.raddr({rb_row, rb_col}), .rdata(rd_b)
	);

	always_comb begin
		if (cmd_s1.op == mae_pkg::FN_MUL) begin
			ma = $signed(rd_a);
			mb = $signed(rd_b);
		end else begin
			ma = $signed(scl_q);
			mb = $signed(rd_a);
		end
		prod = ma * mb;
		case (cmd_s1.op)
			mae_pkg::FN_ADD:   term_c = ACC_W'($signed(rd_a)) + ACC_W'($signed(rd_b));
			mae_pkg::FN_SUB:   term_c = ACC_W'($signed(rd_a)) - ACC_W'($signed(rd_b));
			mae_pkg::FN_MUL, mae_pkg::FN_SCALE: term_c = ACC_W'(prod);
			default:           term_c = ACC_W'($signed(rd_a));
		endcase
		if (cmd_s1.err) begin
			term_c = '0;
		end
	end

	assign acc_next = (cmd_s2.first ? '0 : acc_q) + term_s2;
	assign shifted  = acc_next >>> FRAC_BITS;
	assign fin      = (cmd_s2.op == mae_pkg::FN_MUL || cmd_s2.op == mae_pkg::FN_SCALE)
		? shifted : acc_next;
	// in range when all bits above the sign bit of the result match it
	assign fits = (fin[ACC_W-1:DW-1] == '0) || (fin[ACC_W-1:DW-1] == '1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1      <= '0;
			cmd_s2      <= '0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			cmd_s1      <= cmd;
			cmd_s2      <= cmd_s1;
			out_valid_q <= cmd_s2.vld && cmd_s2.last_k;
			last_q      <= cmd_s2.vld && cmd_s2.last_k && cmd_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scl_ld) begin
			scl_q <= scalar_in;
		end
		row_s1  <= o_row;
		col_s1  <= o_col;
		row_s2  <= row_s1;
		col_s2  <= col_s1;
		term_s2 <= term_c;
		if (cmd_s2.vld) begin
			acc_q <= acc_next;
		end
		if (cmd_s2.vld && cmd_s2.last_k) begin
			out_row   <= row_s2;
			out_col   <= col_s2;
			dim_error <= cmd_s2.err;
			saturated <= !fits;
			if (fits) begin
				result <= fin[DW-1:0];
			end else begin
				result <= fin[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
			end
		end
	end

	assign out_valid = out_valid_q;
	assign last      = last_q;
	assign sts.done  = out_valid_q && last_q;
endmodule
`default_nettype wire

FILE: design/matrix_arith_engine.sv
// Top level of the matrix arithmetic engine: controller plus datapath.
// Depends on mae_pkg, mae_ctrl, mae_dp (and mae_ram through mae_dp).
//
//  channel   handshake                 payload
//  command   start / busy              func, row, col, value, scalar
//  result    out_valid (no stall)      result, out_row, out_col, last, dim_error, saturated
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A load writes its store when in range and busy stays low. An operation issues
// one store read per cycle: one per element for add, subtract, scale and transpose,
// cols_a per element for multiply (one shared multiplier), one per element for a
// mismatched multiply. Results pass through the store read, term and result
// registers after their last read; busy drops the cycle after the last element.
// Reset clears registers to dimension 1; store contents are undefined until loaded.
// The receiver cannot stall.
`default_nettype none
module matrix_arith_engine #(
	parameter int unsigned MAX_DIM    = 8,
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16,
	localparam int unsigned IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [2:0]            func,
	input  wire logic [IDX_W-1:0]      row,
	input  wire logic [IDX_W-1:0]      col,
	input  wire logic [DATA_WIDTH-1:0] value,
	input  wire logic [DATA_WIDTH-1:0] scalar,
	output logic                       out_valid,
	output logic [DATA_WIDTH-1:0]      result,
	output logic [IDX_W-1:0]           out_row,
	output logic [IDX_W-1:0]           out_col,
	output logic                       last,
	output logic                       dim_error,
	output logic                       saturated,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [mae_pkg::CFG_W-1:0] cfg_data
);
	localparam int unsigned ACC_W = 2 * DATA_WIDTH + $clog2(MAX_DIM + 1);

	mae_pkg::cmd_t cmd;
	mae_pkg::sts_t sts;
	logic [IDX_W-1:0] ra_row, ra_col, rb_row, rb_col, o_row, o_col;

	mae_ctrl #(.MAX_DIM(MAX_DIM), .IDX_W(IDX_W)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.row(row), .col(col), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd),
		.ra_row(ra_row), .ra_col(ra_col), .rb_row(rb_row), .rb_col(rb_col),
		.o_row(o_row), .o_col(o_col), .sts(sts)
	);

	mae_dp #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .IDX_W(IDX_W),
		.ACC_W(ACC_W)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .wr_row(row), .wr_col(col),
		.wr_data(value), .scalar_in(scalar), .ra_row(ra_row), .ra_col(ra_col),
		.rb_row(rb_row), .rb_col(rb_col), .o_row(o_row), .o_col(o_col), .sts(sts),
		.out_valid(out_valid), .result(result), .out_row(out_row), .out_col(out_col),
		.last(last), .dim_error(dim_error), .saturated(saturated)
	);
endmodule
`default_nettype wire

FILE: tb/sv/matrix_arith_engine_tb.sv
// Self-checking testbench for matrix_arith_engine: directed table, then random phases.
// Depends on mae_pkg and the design; results are checked against an in-bench predictor.
`default_nettype none
module matrix_arith_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM = 8;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		bit [31:0] res;
		bit [2:0]  r;
		bit [2:0]  c;
		bit        lst;
		bit        err;
		bit        sat;
	} elem_t;

	typedef struct {
		bit [3:0]  ra, ca, rb, cb;
		mae_pkg::func_t fn;
		bit [2:0]  r, c;
		bit [31:0] val, scl;
		bit        typed;
		bit [31:0] t_res;
		bit        t_err, t_sat;
	} vec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] func = '0;
	logic [2:0] row = '0, col = '0;
	logic [31:0] value = '0, scalar = '0;
	logic out_valid;
	logic [31:0] result;
	logic [2:0] out_row, out_col;
	logic last, dim_error, saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [mae_pkg::CFG_W-1:0] cfg_data = '0;

	matrix_arith_engine dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .row(row), .col(col), .value(value), .scalar(scalar),
		.out_valid(out_valid), .result(result), .out_row(out_row), .out_col(out_col),
		.last(last), .dim_error(dim_error), .saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// mirror of the block's state
	bit [3:0]  dim_ra = 1, dim_ca = 1, dim_rb = 1, dim_cb = 1;
	bit [31:0] a_mem [DIM*DIM];
	bit [31:0] b_mem [DIM*DIM];
	bit        a_wr [DIM*DIM];
	bit        b_wr [DIM*DIM];
	elem_t     pending_elems [$];
	int        errors = 0;
	int        idle_pct = 0;
	int        stall_cnt = 0;

	task automatic report(input string msg);
		errors++;
		$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic int eff(input bit [3:0] d);
		if (d == 0) return 1;
		if (d > DIM) return DIM;
		return d;
	endfunction

	function automatic bit [31:0] clip(input logic signed [127:0] v, output bit s);
		s = 1'b0;
		if (v > 128'sd2147483647) begin
			s = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -128'sd2147483648) begin
			s = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	// works out the result matrix of one accepted command word, or mirrors an accepted load
	task automatic predict_matrix(input vec_t v);
		int ra, ca, rb, cb, nr, nc;
		bit err;
		elem_t e;
		logic signed [127:0] acc;
		ra = eff(dim_ra); ca = eff(dim_ca); rb = eff(dim_rb); cb = eff(dim_cb);
		if (v.fn == mae_pkg::FN_LOAD_A) begin
			if (v.r < ra && v.c < ca) begin
				a_mem[v.r*DIM+v.c] = v.val;
				a_wr[v.r*DIM+v.c] = 1'b1;
			end
			return;
		end
		if (v.fn == mae_pkg::FN_LOAD_B) begin
			if (v.r < rb && v.c < cb) begin
				b_mem[v.r*DIM+v.c] = v.val;
				b_wr[v.r*DIM+v.c] = 1'b1;
			end
			return;
		end
		if (v.fn == mae_pkg::FN_NONE) return;
		nr = ra; nc = ca; err = 1'b0;
		if (v.fn == mae_pkg::FN_ADD || v.fn == mae_pkg::FN_SUB) err = (ra != rb || ca != cb);
		else if (v.fn == mae_pkg::FN_MUL) begin
			nc = cb;
			err = (ca != rb);
		end else if (v.fn == mae_pkg::FN_TRANS) begin
			nr = ca;
			nc = ra;
		end
		for (int i = 0; i < nr; i++) begin
			for (int j = 0; j < nc; j++) begin
				e.res = '0; e.sat = 1'b0; e.err = err;
				e.r = 3'(i); e.c = 3'(j); e.lst = (i == nr-1 && j == nc-1);
				if (!err) begin
					case (v.fn)
						mae_pkg::FN_ADD, mae_pkg::FN_SUB: begin
							acc = $signed(a_mem[i*DIM+j]);
							if (v.fn == mae_pkg::FN_ADD) acc = acc + $signed(b_mem[i*DIM+j]);
							else acc = acc - $signed(b_mem[i*DIM+j]);
							e.res = clip(acc, e.sat);
						end
						mae_pkg::FN_MUL: begin
							acc = '0;
							for (int k = 0; k < ca; k++)
								acc = acc + $signed(a_mem[i*DIM+k]) * $signed(b_mem[k*DIM+j]);
							acc = acc >>> 16;
							e.res = clip(acc, e.sat);
						end
						mae_pkg::FN_SCALE: begin
							acc = $signed(v.scl) * $signed(a_mem[i*DIM+j]);
							acc = acc >>> 16;
							e.res = clip(acc, e.sat);
						end
						default: e.res = a_mem[j*DIM+i];
					endcase
				end
				if (v.typed) begin
					e.res = v.t_res; e.err = v.t_err; e.sat = v.t_sat;
				end
				pending_elems.push_back(e);
			end
		end
	endtask

	// command word stays up until accepted; start is only lowered by a gap or release
	task automatic issue_cmd(input vec_t v);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		func <= v.fn; row <= v.r; col <= v.c; value <= v.val; scalar <= v.scl;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_matrix(v);
	endtask

	function automatic bit [31:0] pick_word();
		case ($urandom_range(9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(0, 32'h3ffff) - 32'h20000;
			default: return $urandom;
		endcase
	endfunction

	// loads any element that an operation would read before it was ever written
	task automatic fill_elem(input mae_pkg::func_t fn, input int i, input int j);
		vec_t ld;
		if (fn == mae_pkg::FN_LOAD_A && a_wr[i*DIM+j]) return;
		if (fn == mae_pkg::FN_LOAD_B && b_wr[i*DIM+j]) return;
		ld = '{fn: mae_pkg::FN_NONE, default: 0};
		ld.fn = fn;
		ld.r = 3'(i); ld.c = 3'(j);
		ld.val = pick_word();
		issue_cmd(ld);
	endtask

	task automatic cover_reads(input mae_pkg::func_t fn);
		int ra, ca, rb, cb;
		ra = eff(dim_ra); ca = eff(dim_ca); rb = eff(dim_rb); cb = eff(dim_cb);
		case (fn)
			mae_pkg::FN_ADD, mae_pkg::FN_SUB: begin
				if (ra == rb && ca == cb)
					for (int i = 0; i < ra; i++)
						for (int j = 0; j < ca; j++) begin
							fill_elem(mae_pkg::FN_LOAD_A, i, j);
							fill_elem(mae_pkg::FN_LOAD_B, i, j);
						end
			end
			mae_pkg::FN_MUL: begin
				if (ca == rb) begin
					for (int i = 0; i < ra; i++)
						for (int k = 0; k < ca; k++)
							fill_elem(mae_pkg::FN_LOAD_A, i, k);
					for (int k = 0; k < rb; k++)
						for (int j = 0; j < cb; j++)
							fill_elem(mae_pkg::FN_LOAD_B, k, j);
				end
			end
			mae_pkg::FN_SCALE, mae_pkg::FN_TRANS: begin
				for (int i = 0; i < ra; i++)
					for (int j = 0; j < ca; j++)
						fill_elem(mae_pkg::FN_LOAD_A, i, j);
			end
			default: begin
			end
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_elems.size() != 0 || busy) @(posedge clk);
		// loads give no results; allow the pipeline to settle
		repeat (8) @(posedge clk);
	endtask

	task automatic cfg_write(input mae_pkg::reg_idx_t idx, input bit [3:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			mae_pkg::REG_ROWS_A: dim_ra = d;
			mae_pkg::REG_COLS_A: dim_ca = d;
			mae_pkg::REG_ROWS_B: dim_rb = d;
			mae_pkg::REG_COLS_B: dim_cb = d;
			default: begin
			end
		endcase
	endtask

	task automatic set_dims(input bit [3:0] ra, ca, rb, cb);
		drain();
		cfg_write(mae_pkg::REG_ROWS_A, ra);
		cfg_write(mae_pkg::REG_COLS_A, ca);
		cfg_write(mae_pkg::REG_ROWS_B, rb);
		cfg_write(mae_pkg::REG_COLS_B, cb);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit [3:0] pick_dim();
		int p;
		p = $urandom_range(99);
		if (p < 80) return 4'($urandom_range(1, 3));
		if (p < 88) return 4'd0;
		if (p < 94) return 4'd8;
		return 4'($urandom_range(9, 15));
	endfunction

	// result checker: the receiver never stalls
	always @(posedge clk) begin
		elem_t e;
		if (arst_n && out_valid) begin
			if (pending_elems.size() == 0) begin
				report($sformatf("unexpected result word %h", result));
			end else begin
				e = pending_elems.pop_front();
				if (result !== e.res)
					report($sformatf("result %h, want %h", result, e.res));
				if (out_row !== e.r) report($sformatf("out_row %0d, want %0d", out_row, e.r));
				if (out_col !== e.c) report($sformatf("out_col %0d, want %0d", out_col, e.c));
				if (last !== e.lst) report($sformatf("last %b, want %b", last, e.lst));
				if (dim_error !== e.err)
					report($sformatf("dim_error %b, want %b", dim_error, e.err));
				if (saturated !== e.sat)
					report($sformatf("saturated %b, want %b", saturated, e.sat));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || out_valid) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	vec_t dir_tbl [] = '{
		'{1,1,1,1, mae_pkg::FN_LOAD_A, 0,0, 32'h7fffffff, 0, 0, 0, 0, 0},
		'{1,1,1,1, mae_pkg::FN_LOAD_B, 0,0, 32'h7fffffff, 0, 0, 0, 0, 0},
		'{1,1,1,1, mae_pkg::FN_ADD,    0,0, 0, 0, 1, 32'h7fffffff, 0, 1},
		'{1,1,1,1, mae_pkg::FN_LOAD_B, 0,0, 32'h80000000, 0, 0, 0, 0, 0},
		'{1,1,1,1, mae_pkg::FN_SUB,    0,0, 0, 0, 1, 32'h7fffffff, 0, 1},
		'{1,1,1,1, mae_pkg::FN_LOAD_A, 0,0, 32'h80000000, 0, 0, 0, 0, 0},
		'{1,1,1,1, mae_pkg::FN_SUB,    0,0, 0, 0, 1, 32'h00000000, 0, 0},
		'{1,1,1,1, mae_pkg::FN_ADD,    0,0, 0, 0, 1, 32'h80000000, 0, 1},
		'{1,1,1,1, mae_pkg::FN_LOAD_A, 7,7, 32'h12345678, 0, 0, 0, 0, 0},
		'{1,1,1,1, mae_pkg::FN_TRANS,  0,0, 0, 0, 1, 32'h80000000, 0, 0},
		'{1,1,1,1, mae_pkg::FN_MUL,    0,0, 0, 0, 1, 32'h7fffffff, 0, 1},
		'{1,1,1,1, mae_pkg::FN_SCALE,  0,0, 0, 32'h00010000, 1, 32'h80000000, 0, 0},
		'{1,1,1,1, mae_pkg::FN_SCALE,  0,0, 0, 32'h00000000, 1, 32'h00000000, 0, 0},
		'{1,1,1,1, mae_pkg::FN_NONE,   7,7, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0},
		'{2,3,3,2, mae_pkg::FN_ADD,    0,0, 0, 0, 1, 32'h00000000, 1, 0},
		'{2,3,3,2, mae_pkg::FN_MUL,    0,0, 0, 0, 0, 0, 0, 0},
		'{2,3,3,2, mae_pkg::FN_TRANS,  0,0, 0, 0, 0, 0, 0, 0},
		'{8,1,1,8, mae_pkg::FN_LOAD_A, 7,0, 32'h7fffffff, 0, 0, 0, 0, 0},
		'{8,1,1,8, mae_pkg::FN_LOAD_B, 0,7, 32'h80000000, 0, 0, 0, 0, 0},
		'{8,1,1,8, mae_pkg::FN_MUL,    0,0, 0, 0, 0, 0, 0, 0},
		'{8,1,1,8, mae_pkg::FN_SCALE,  0,0, 0, 32'h7fffffff, 0, 0, 0, 0},
		'{0,15,15,0, mae_pkg::FN_MUL,  0,0, 0, 0, 0, 0, 0, 0},
		'{0,15,15,0, mae_pkg::FN_SUB,  0,0, 0, 0, 1, 32'h00000000, 1, 0},
		'{8,1,2,8, mae_pkg::FN_MUL,    0,0, 0, 0, 1, 32'h00000000, 1, 0}
	};

	initial begin
		vec_t v;
		int mode;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tbl[n]) begin
			v = dir_tbl[n];
			if (v.ra != dim_ra || v.ca != dim_ca || v.rb != dim_rb || v.cb != dim_cb)
				set_dims(v.ra, v.ca, v.rb, v.cb);
			cover_reads(v.fn);
			issue_cmd(v);
		end

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = (ph == 0) ? 30 : (ph == 1) ? 55 : 0;
			for (int n = 0; n < 15; n++) begin
				if (n % 8 == 0) begin
					v.ra = pick_dim(); v.ca = pick_dim();
					mode = $urandom_range(2);
					v.rb = (mode == 0) ? v.ra : (mode == 1) ? v.ca : pick_dim();
					v.cb = (mode == 0) ? v.ca : pick_dim();
					set_dims(v.ra, v.ca, v.rb, v.cb);
				end
				v = '{fn: mae_pkg::FN_NONE, default: 0};
				v.fn = mae_pkg::func_t'($urandom_range(7));
				if ($urandom_range(99) < 45) v.fn = mae_pkg::func_t'($urandom_range(1));
				if ($urandom_range(99) < 80) begin
					v.r = 3'($urandom_range((v.fn == mae_pkg::FN_LOAD_B) ?
						eff(dim_rb) - 1 : eff(dim_ra) - 1));
					v.c = 3'($urandom_range((v.fn == mae_pkg::FN_LOAD_B) ?
						eff(dim_cb) - 1 : eff(dim_ca) - 1));
				end else begin
					v.r = 3'($urandom_range(7));
					v.c = 3'($urandom_range(7));
				end
				v.val = pick_word();
				v.scl = pick_word();
				cover_reads(v.fn);
				issue_cmd(v);
			end
		end

		drain();
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
`default_nettype wire
